// ----- hw/rtl/mdcm_pkg.sv -----
// shared constants, codes and helper functions of the mecanum drive command mixer
// no dependencies; imported by the mixer top level and its port checker
`default_nettype none

package mdcm_pkg;

    localparam int unsigned NUM_WHEELS  = 4;
    localparam int unsigned NUM_MIX_BTN = 6;

    // operation codes carried in tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_SERIAL = 2'd2;

    // direction codes, two bits per wheel
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_BACK = 2'b10;
    localparam logic [1:0] DIR_STOP = 2'b11;

    localparam logic [7:0]  POWER_CAP       = 8'd204;
    localparam logic [6:0]  LEVEL_FULL      = 7'd100;
    localparam logic [6:0]  LEVEL_HALF      = 7'd50;
    localparam logic [16:0] IDLE_MAX        = 17'h1FFFF;
    localparam logic [15:0] TIMEOUT_DEFAULT = 16'd100;

    // button bit positions for the drive level
    localparam int unsigned BTN_A = 6;
    localparam int unsigned BTN_B = 7;

    // wheel index order FL FR BL BR
    localparam int unsigned W_FL = 0;
    localparam int unsigned W_FR = 1;
    localparam int unsigned W_BL = 2;
    localparam int unsigned W_BR = 3;

    typedef logic signed [7:0] speed_t;
    typedef logic signed [2:0] mix_sum_t;

    // per-button wheel pattern, buttons up down left right select start
    localparam logic signed [1:0] MIX_TABLE [NUM_MIX_BTN][NUM_WHEELS] = '{
        '{ 2'sd1,  2'sd1,  2'sd1,  2'sd1},
        '{-2'sd1, -2'sd1, -2'sd1, -2'sd1},
        '{-2'sd1,  2'sd1,  2'sd1, -2'sd1},
        '{ 2'sd1, -2'sd1, -2'sd1,  2'sd1},
        '{-2'sd1,  2'sd1, -2'sd1,  2'sd1},
        '{ 2'sd1, -2'sd1,  2'sd1, -2'sd1}
    };

    function automatic logic [1:0] mix_mag(input mix_sum_t s);
        mix_mag = s[2] ? 2'(-s) : s[1:0];
    endfunction

    function automatic logic [1:0] dir_of(input speed_t s);
        if (s == 8'sd0) begin
            dir_of = DIR_STOP;
        end else if (s[7]) begin
            dir_of = DIR_BACK;
        end else begin
            dir_of = DIR_FWD;
        end
    endfunction

    function automatic logic [7:0] power_of(input speed_t s);
        logic [7:0] m;
        logic [8:0] p;
        m = s[7] ? 8'(-s) : 8'(s);
        p = {m, 1'b0};
        if (s == 8'sd0) begin
            power_of = POWER_CAP;
        end else if (p > {1'b0, POWER_CAP}) begin
            power_of = POWER_CAP;
        end else begin
            power_of = p[7:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mecanum_drive_command_mixer.sv -----
// mecanum drive command mixer: button mixing, serial speeds, idle timeout, motor outputs
// depends on mdcm_pkg; one shared compare-subtract divider under a small sequencer
// sequence: tick, serial, no-command and unused items set the done flag, and the result
//   loads once the output register is free; a button command runs mix, then for each of
//   the 4 wheels a load step and the divider steps of 3 quotient bits each, then output
// throughput: one item at a time; s_tready is high only while idle and no result waits
// reset: synchronous active-low aresetn clears speeds, idle count, output valid,
//   sets drive level 50 and timeout 100 ms
`default_nettype none

module mecanum_drive_command_mixer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: timeout_ms
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // buttons, cmd_speed_fl, cmd_speed_fr, cmd_speed_bl, cmd_speed_br
    input  wire logic [39:0] s_tdata,
    // operation
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // direction_code, power_fl, power_fr, power_bl, power_br
    output logic [39:0]      m_tdata
);

    import mdcm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_LOAD,
        ST_DIV
    } state_t;

    // extra state for output hand-off
    logic   done_reg;

    state_t     state_reg;
    speed_t     wheel_speed_reg [NUM_WHEELS];
    logic [6:0] drive_level_reg;
    logic [16:0] idle_count_reg;
    logic [15:0] timeout_reg;

    // captured button sample and mix results
    logic [7:0] btn_reg;
    mix_sum_t   sum_reg [NUM_WHEELS];
    logic [1:0] den_reg;
    logic [1:0] wheel_idx_reg;

    // shared divider: dividend shifts out on top, quotient bits shift in below
    logic [8:0] dvd_reg;
    logic [1:0] rem_reg;
    logic [1:0] step_reg;
    logic [8:0] dvd_next;
    logic [1:0] rem_next;
    logic [2:0] div_trial;

    logic       m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    mix_sum_t   mix_sum [NUM_WHEELS];
    logic [1:0] mix_den;
    logic [6:0] level_next;
    logic [8:0] dividend;
    logic [7:0] quot;
    speed_t     quot_signed;
    logic       in_xfer;
    logic       out_free;
    logic       timed_out;
    speed_t     speed_eff [NUM_WHEELS];
    logic [39:0] result;

    assign s_tready = (state_reg == ST_IDLE) && !done_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // button pattern sums and the largest wheel magnitude, at least 1
    always_comb begin
        mix_den = 2'd1;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            mix_sum[w] = 3'sd0;
            for (int b = 0; b < NUM_MIX_BTN; b++) begin
                if (btn_reg[b]) begin
                    mix_sum[w] = mix_sum[w] + 3'(MIX_TABLE[b][w]);
                end
            end
        end
        for (int w = 0; w < NUM_WHEELS; w++) begin
            if (mix_mag(mix_sum[w]) > mix_den) begin
                mix_den = mix_mag(mix_sum[w]);
            end
        end
    end

    // A wins over B
    always_comb begin
        if (btn_reg[BTN_A]) begin
            level_next = LEVEL_FULL;
        end else if (btn_reg[BTN_B]) begin
            level_next = LEVEL_HALF;
        end else begin
            level_next = drive_level_reg;
        end
    end

    // magnitude times drive level for the wheel under work, at most 300
    assign dividend = 9'(mix_mag(sum_reg[wheel_idx_reg])) * 9'(drive_level_reg);

    // three restoring division steps per cycle
    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_trial = 3'd0;
        for (int i = 0; i < 3; i++) begin
            div_trial = {rem_next, dvd_next[8]};
            if (div_trial >= {1'b0, den_reg}) begin
                div_trial = div_trial - {1'b0, den_reg};
                dvd_next  = {dvd_next[7:0], 1'b1};
            end else begin
                dvd_next  = {dvd_next[7:0], 1'b0};
            end
            rem_next = div_trial[1:0];
        end
    end

    // quotient never exceeds the drive level, so 8 bits hold it
    assign quot        = dvd_next[7:0];
    assign quot_signed = sum_reg[wheel_idx_reg][2] ? -speed_t'(quot) : speed_t'(quot);

    // timeout check after the item's own effect, then outputs
    assign timed_out = idle_count_reg > {1'b0, timeout_reg};

    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            speed_eff[w] = timed_out ? 8'sd0 : wheel_speed_reg[w];
        end
        result[1:0]   = dir_of(speed_eff[W_FR]);
        result[3:2]   = dir_of(speed_eff[W_FL]);
        result[5:4]   = dir_of(speed_eff[W_BL]);
        result[7:6]   = dir_of(speed_eff[W_BR]);
        result[15:8]  = power_of(speed_eff[W_FL]);
        result[23:16] = power_of(speed_eff[W_FR]);
        result[31:24] = power_of(speed_eff[W_BL]);
        result[39:32] = power_of(speed_eff[W_BR]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            drive_level_reg <= LEVEL_HALF;
            idle_count_reg  <= '0;
            timeout_reg     <= TIMEOUT_DEFAULT;
            wheel_idx_reg   <= '0;
            step_reg        <= '0;
            for (int w = 0; w < NUM_WHEELS; w++) begin
                wheel_speed_reg[w] <= 8'sd0;
            end
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end

            // output register empties on a result transfer unless the next result loads
            if (m_tvalid_reg && m_tready && !done_reg) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (done_reg) begin
                        // result transfer waits for a free output register
                        if (out_free) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= result;
                            done_reg     <= 1'b0;
                            if (timed_out) begin
                                for (int w = 0; w < NUM_WHEELS; w++) begin
                                    wheel_speed_reg[w] <= 8'sd0;
                                end
                            end
                        end
                    end else if (in_xfer) begin
                        btn_reg <= s_tdata[7:0];
                        case (s_tuser)
                            OP_TICK: begin
                                if (idle_count_reg != IDLE_MAX) begin
                                    idle_count_reg <= idle_count_reg + 17'd1;
                                end
                                done_reg <= 1'b1;
                            end
                            OP_BUTTON: begin
                                if (s_tdata[7:0] != 8'd0) begin
                                    idle_count_reg <= '0;
                                    state_reg      <= ST_MIX;
                                end else begin
                                    done_reg <= 1'b1;
                                end
                            end
                            OP_SERIAL: begin
                                wheel_speed_reg[W_FL] <= s_tdata[15:8];
                                wheel_speed_reg[W_FR] <= s_tdata[23:16];
                                wheel_speed_reg[W_BL] <= s_tdata[31:24];
                                wheel_speed_reg[W_BR] <= s_tdata[39:32];
                                idle_count_reg        <= '0;
                                done_reg              <= 1'b1;
                            end
                            default: begin
                                // unused code: no command, no tick
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_MIX: begin
                    for (int w = 0; w < NUM_WHEELS; w++) begin
                        sum_reg[w] <= mix_sum[w];
                    end
                    den_reg         <= mix_den;
                    drive_level_reg <= level_next;
                    wheel_idx_reg   <= '0;
                    state_reg       <= ST_LOAD;
                end
                ST_LOAD: begin
                    dvd_reg   <= dividend;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd2) begin
                        wheel_speed_reg[wheel_idx_reg] <= quot_signed;
                        if (wheel_idx_reg == 2'(NUM_WHEELS - 1)) begin
                            state_reg <= ST_IDLE;
                            done_reg  <= 1'b1;
                        end else begin
                            wheel_idx_reg <= wheel_idx_reg + 2'd1;
                            state_reg     <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mdcm_checker.sv -----
// port-level checker for the mecanum drive command mixer, bound to the top level
// depends on mdcm_pkg and mecanum_drive_command_mixer
`default_nettype none

module mdcm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    import mdcm_pkg::*;

    // busy after an input transfer
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // no output right out of reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // powers are even and capped
    a_power_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:8] <= POWER_CAP && m_tdata[23:16] <= POWER_CAP &&
                      m_tdata[31:24] <= POWER_CAP && m_tdata[39:32] <= POWER_CAP &&
                      !m_tdata[8] && !m_tdata[16] && !m_tdata[24] && !m_tdata[32]))
        else $error("power out of range");

    // a stopped wheel brakes at full power, no zero direction code
    a_stop_brakes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[1:0] != DIR_STOP || m_tdata[23:16] == POWER_CAP) &&
                      (m_tdata[3:2] != DIR_STOP || m_tdata[15:8] == POWER_CAP) &&
                      (m_tdata[5:4] != DIR_STOP || m_tdata[31:24] == POWER_CAP) &&
                      (m_tdata[7:6] != DIR_STOP || m_tdata[39:32] == POWER_CAP) &&
                      m_tdata[1:0] != 2'b00 && m_tdata[3:2] != 2'b00 &&
                      m_tdata[5:4] != 2'b00 && m_tdata[7:6] != 2'b00))
        else $error("direction and power disagree");

endmodule

bind mecanum_drive_command_mixer mdcm_checker u_mdcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
